FILE: rtl/imh_pkg.sv
package imh_pkg;
  localparam int HEAP_DEPTH_DEF   = 1024;
  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int KEY_BITS_DEF     = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,   // delete: read last entry
    S_WR_HOLE,   // delete: place it in the hole
    S_UP_RD,     // sift up: read parent
    S_UP_CMP,    // sift up: compare, swap
    S_DN_RDL,    // sift down: read left child
    S_DN_RDR,    // sift down: read right child
    S_DN_CMP,    // sift down: compare, swap
    S_MAP,       // second map write of a swap
    S_TOP,       // read slot 0
    S_OUT
  } state_t;
endpackage

FILE: rtl/indexed_max_heap_core.sv
// Channel  Direction  Fields (tdata low bit up)
// in_      slave      opcode[1:0] vertex_id[11:2] entry_key[43:12] heap_slot[53:44], 56 bits
// out_     master     top_vertex[9:0] top_key[41:10] entry_count[52:42]
//                     vertex_slot[63:53] status[65:64], 72 bits
// An insert rises through S_UP_RD, S_UP_CMP and S_MAP for each level. A delete runs
// S_RD_LAST and S_WR_HOLE, then sinks through S_DN_RDL, S_DN_RDR, S_DN_CMP and S_MAP
// for each level, and may then rise. A query or a rejected operation goes through S_TOP
// and S_OUT only. The single-port heap memory sets this pace.
// After reset a clearing pass marks every vertex absent before the first
// transfer is accepted. in_tready is low while an operation
// runs and while a result waits on out_tready.
module indexed_max_heap_core
  import imh_pkg::*;
#(
  parameter int HEAP_DEPTH   = HEAP_DEPTH_DEF,
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // opcode, vertex_id, entry_key, heap_slot
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // top_vertex, top_key, entry_count, vertex_slot, status
);
  localparam int HA = $clog2(HEAP_DEPTH);
  localparam int VA = $clog2(VERTEX_COUNT);
  localparam int CW = HA + 1;
  localparam int EW = 10 + KEY_BITS;

  state_t state_r, state_nxt;

  logic [EW-1:0] heap_mem [HEAP_DEPTH];
  logic [10:0]   map_mem  [VERTEX_COUNT];

  // Heap port
  logic          h_we;
  logic [HA-1:0] h_addr;
  logic [EW-1:0] h_wd, h_rd_r;
  // Map port
  logic          m_we;
  logic [VA-1:0] m_addr;
  logic [10:0]   m_wd, m_rd_r;

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_addr] <= h_wd;
    h_rd_r <= heap_mem[h_addr];
  end
  always_ff @(posedge clk) begin
    if (m_we) map_mem[m_addr] <= m_wd;
    m_rd_r <= map_mem[m_addr];
  end

  logic          clr_r;
  logic [VA:0]   clr_cnt_r;
  logic [CW-1:0] cnt_r;
  logic [HA-1:0] cur_r, oth_r, best_r;
  logic [EW-1:0] cur_e_r, best_e_r;
  logic [10:0]   qslot_r;
  status_t       stat_r;
  logic          phase_r;  // delete: 0 sink, 1 rise
  logic [1:0]    op_r;
  logic [9:0]    vin_r;
  logic [71:0]   out_r;
  logic          ov_r;

  logic [1:0]           i_op;
  logic [9:0]           i_v, i_hs;
  logic [KEY_BITS-1:0]  i_key;
  assign i_op  = in_tdata[1:0];
  assign i_v   = in_tdata[11:2];
  assign i_key = in_tdata[12 +: KEY_BITS];
  assign i_hs  = in_tdata[53:44];

  assign in_tready  = (state_r == S_IDLE) && !clr_r && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;
  logic acc;
  assign acc = in_tvalid && in_tready;

  logic [KEY_BITS-1:0] cur_k, rd_k, best_k;
  assign cur_k  = cur_e_r[10 +: KEY_BITS];
  assign rd_k   = h_rd_r[10 +: KEY_BITS];
  assign best_k = best_e_r[10 +: KEY_BITS];

  logic [HA:0] lchild;
  assign lchild = {cur_r, 1'b0} + (HA+1)'(1);

  // right child read data compared against current best in S_DN_CMP
  logic [HA:0] rchild;
  assign rchild = lchild + (HA+1)'(1);
  logic dn_swap;
  logic [HA-1:0] dn_best;
  logic [EW-1:0] dn_best_e;
  always_comb begin
    dn_best = best_r;
    dn_best_e = best_e_r;
    if (rchild < (HA+1)'(cnt_r) && rd_k > best_k) begin
      dn_best = HA'(rchild);
      dn_best_e = h_rd_r;
    end
    dn_swap = dn_best != cur_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc) begin
        priority if (i_op == OP_INSERT) begin
          if (32'(i_v) >= VERTEX_COUNT || 32'(cnt_r) >= HEAP_DEPTH) state_nxt = S_TOP;
          else state_nxt = S_UP_RD;
        end else if (i_op == OP_DELETE) begin
          if (32'(i_hs) >= 32'(cnt_r)) state_nxt = S_TOP;
          else state_nxt = S_RD_LAST;
        end else if (i_op == OP_QUERY) state_nxt = S_TOP;
        else state_nxt = S_TOP;
      end
      S_RD_LAST: state_nxt = S_WR_HOLE;
      S_WR_HOLE: state_nxt = (cur_r == HA'(cnt_r)) ? S_TOP : S_DN_RDL;
      S_UP_RD:   state_nxt = (cur_r == '0) ? S_TOP : S_UP_CMP;
      S_UP_CMP:  state_nxt = (cur_k > rd_k) ? S_MAP : S_TOP;
      S_DN_RDL:  state_nxt = (lchild < (HA+1)'(cnt_r)) ? S_DN_RDR : S_UP_RD;
      S_DN_RDR:  state_nxt = S_DN_CMP;
      S_DN_CMP:  state_nxt = dn_swap ? S_MAP : S_UP_RD;
      S_MAP:     state_nxt = phase_r ? S_UP_RD : S_DN_RDL;
      S_TOP:     state_nxt = S_OUT;
      S_OUT:     state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    h_we = 1'b0; h_addr = cur_r; h_wd = cur_e_r;
    m_we = 1'b0; m_addr = VA'(vin_r); m_wd = 11'h7FF;
    if (clr_r) begin
      m_we = 1'b1; m_addr = clr_cnt_r[VA-1:0]; m_wd = 11'h7FF;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          m_addr = VA'(i_v);
          h_addr = HA'(i_hs);
          if (acc && i_op == OP_INSERT && 32'(i_v) < VERTEX_COUNT &&
              32'(cnt_r) < HEAP_DEPTH) begin
            h_we = 1'b1; h_addr = HA'(cnt_r);
            h_wd = {i_key, i_v};
            m_we = 1'b1; m_wd = 11'(cnt_r);
          end
        end
        S_RD_LAST: begin
          // Victim vertex is in h_rd_r; mark it absent, read last.
          m_we = 1'b1; m_addr = VA'(h_rd_r[9:0]); m_wd = 11'h7FF;
          h_addr = HA'(cnt_r - CW'(1));
        end
        S_WR_HOLE: begin
          if (cur_r != HA'(cnt_r)) begin
            h_we = 1'b1; h_addr = cur_r; h_wd = h_rd_r;
            m_we = 1'b1; m_addr = VA'(h_rd_r[9:0]); m_wd = 11'(cur_r);
          end
        end
        S_UP_RD:  h_addr = (cur_r - HA'(1)) >> 1;
        S_UP_CMP: if (cur_k > rd_k) begin
          h_we = 1'b1; h_addr = cur_r; h_wd = h_rd_r;
          m_we = 1'b1; m_addr = VA'(h_rd_r[9:0]); m_wd = 11'(cur_r);
        end
        S_DN_RDL: h_addr = HA'(lchild);
        S_DN_RDR: h_addr = HA'(rchild);
        // The moving vertex is mapped first, so a vertex held twice ends up
        // pointing at the upper slot.
        S_DN_CMP: if (dn_swap) begin
          h_we = 1'b1; h_addr = cur_r; h_wd = dn_best_e;
          m_we = 1'b1; m_addr = VA'(cur_e_r[9:0]); m_wd = 11'(dn_best);
        end
        S_MAP: begin
          h_we = 1'b1; h_addr = oth_r; h_wd = cur_e_r;
          m_we = 1'b1;
          if (phase_r) begin
            m_addr = VA'(cur_e_r[9:0]); m_wd = 11'(oth_r);
          end else begin
            m_addr = VA'(best_e_r[9:0]); m_wd = 11'(cur_r);
          end
        end
        S_TOP: h_addr = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      cnt_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + (VA+1)'(1);
        if (clr_cnt_r == (VA+1)'(VERTEX_COUNT - 1)) clr_r <= 1'b0;
      end
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (state_r == S_IDLE && acc && i_op == OP_INSERT &&
          32'(i_v) < VERTEX_COUNT && 32'(cnt_r) < HEAP_DEPTH)
        cnt_r <= cnt_r + CW'(1);
      if (state_r == S_RD_LAST) cnt_r <= cnt_r - CW'(1);
      if (state_r == S_OUT) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (acc) begin
        op_r <= i_op; vin_r <= i_v;
        qslot_r <= 11'h7FF; stat_r <= ST_OK; phase_r <= 1'b1;
        cur_r <= HA'(cnt_r); cur_e_r <= {i_key, i_v};
        priority if (i_op == OP_INSERT) begin
          if (32'(i_v) >= VERTEX_COUNT) stat_r <= ST_RANGE;
          else if (32'(cnt_r) >= HEAP_DEPTH) stat_r <= ST_FULL;
        end else if (i_op == OP_DELETE) begin
          cur_r <= HA'(i_hs); phase_r <= 1'b0;
          if (32'(i_hs) >= 32'(cnt_r)) stat_r <= ST_RANGE;
        end else if (i_op == OP_QUERY) begin
          if (32'(i_v) >= VERTEX_COUNT) stat_r <= ST_RANGE;
        end else ;
      end
      S_WR_HOLE: cur_e_r <= h_rd_r;
      S_UP_CMP: if (cur_k > rd_k) begin
        oth_r <= (cur_r - HA'(1)) >> 1;
        phase_r <= 1'b1;
      end
      S_DN_RDL: begin best_r <= cur_r; best_e_r <= cur_e_r; end
      S_DN_RDR: if (rd_k > cur_k) begin best_r <= HA'(lchild); best_e_r <= h_rd_r; end
      S_DN_CMP: begin
        oth_r <= dn_best;
        best_e_r <= dn_best_e;
        if (!dn_swap) phase_r <= 1'b1;
      end
      S_MAP: cur_r <= oth_r;
      S_TOP: if (op_r == OP_QUERY && stat_r == ST_OK) qslot_r <= m_rd_r;
      S_OUT: begin
        out_r[9:0]   <= (cnt_r != '0) ? h_rd_r[9:0] : 10'd0;
        out_r[41:10] <= (cnt_r != '0) ? 32'(h_rd_r[10 +: KEY_BITS]) : 32'd0;
        out_r[52:42] <= 11'(cnt_r);
        out_r[63:53] <= qslot_r;
        out_r[65:64] <= stat_r;
        out_r[71:66] <= '0;
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/imh_checker.sv
module imh_checker
  import imh_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [55:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out held");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:64] != ST_FULL || out_tdata[63:53] == 11'h7FF)
    else $error("full with slot");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[52:42] == 11'd0 |-> out_tdata[41:0] == 42'd0)
    else $error("empty top");
endmodule

bind indexed_max_heap_core imh_checker u_imh_checker (.*);
